FILE: rtl/lob_pkg.sv
package lob_pkg;

  localparam int ORDER_SLOTS = 1024;
  localparam int PRICE_TICKS = 4096;
  localparam int MAX_DEPTH   = 16;
  localparam int QTY_BITS    = 24;

  localparam int HANDLE_W   = $clog2(ORDER_SLOTS);
  localparam int PRICE_W    = $clog2(PRICE_TICKS);
  localparam int QTY_W      = QTY_BITS;
  localparam int CNT_W      = 5;
  localparam int VOL_W      = 34;
  localparam int SUM_W      = VOL_W + 4;
  localparam int LVL_ADDR_W = PRICE_W + 1;
  localparam int PROD_W     = QTY_W + PRICE_W;
  localparam int DIV_NUM_W  = 56;
  localparam int DIV_DEN_W  = 40;
  localparam int DIV_CNT_W  = $clog2(DIV_NUM_W);
  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 144;
  localparam int IMB_DEPTH_RESET = 5;

  typedef enum logic [2:0] {
    ACT_ADD,
    ACT_MODIFY,
    ACT_CANCEL,
    ACT_IMPACT,
    ACT_DEPTH_BID,
    ACT_DEPTH_ASK,
    ACT_NOP
  } act_t;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_UNKNOWN = 2'd1,
    STAT_REJECT  = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_SLOT_CK,
    S_LVL_WR,
    S_WALK_RD,
    S_WALK_CK,
    S_WALK_ACC,
    S_DIV_START,
    S_DIV_WAIT,
    S_EMIT_LVL,
    S_EMIT_ONE
  } state_t;

  typedef enum logic [2:0] {
    PH_BEST_BID,
    PH_BEST_ASK,
    PH_IMB_BID,
    PH_IMB_ASK,
    PH_IMPACT,
    PH_COUNT,
    PH_LEVELS
  } phase_t;

  typedef struct packed {
    act_t                act;
    logic [HANDLE_W-1:0] handle;
    logic                buy;
    logic [PRICE_W-1:0]  price;
    logic [QTY_W-1:0]    qty;
    logic [CNT_W-1:0]    cnt;
  } cmd_t;

  typedef struct packed {
    logic                valid;
    logic                side;
    logic [PRICE_W-1:0]  price;
    logic [QTY_W-1:0]    qty;
  } slot_t;

  typedef struct packed {
    logic [3:0]          pad;
    logic [CNT_W-1:0]    level_count;
    logic [QTY_W-1:0]    quantity;
    logic [PRICE_W-1:0]  price;
    logic                is_buy;
    logic [HANDLE_W-1:0] order_handle;
  } in_word_t;

  typedef struct packed {
    logic [4:0]          pad;
    logic [VOL_W-1:0]    level_volume;
    logic [PRICE_W-1:0]  level_price;
    logic [23:0]         impact_fine;
    logic [15:0]         imbalance_q15;
    logic [11:0]         spread_ticks;
    logic [12:0]         mid_doubled;
    logic                ask_present;
    logic                bid_present;
    logic [11:0]         best_ask;
    logic [11:0]         best_bid;
    logic [1:0]          status;
  } out_word_t;

  // Zero reads as one level, anything deeper than the book supports is capped.
  function automatic logic [CNT_W-1:0] clamp_depth(input logic [CNT_W-1:0] n);
    logic [CNT_W-1:0] r;
    if (n == '0) begin
      r = CNT_W'(1);
    end else if (n > CNT_W'(MAX_DEPTH)) begin
      r = CNT_W'(MAX_DEPTH);
    end else begin
      r = n;
    end
    return r;
  endfunction

endpackage

FILE: rtl/limit_order_book_engine_core.sv
// Limit order book engine.
// Input items arrive on the in_ stream: in_tuser carries the action (add, modify,
// cancel, impact query, bid depth, ask depth) and in_tdata the order fields. Each
// item produces one result transfer on the out_ stream, or up to sixteen for a
// depth read, with out_tlast set on the final transfer of the item. Every result
// carries the top of book, the volume imbalance over the configured depth and,
// for queries, the impact or one depth level. cfg_wr_en writes the imbalance
// depth register. Items pass through a two-entry queue to a sequencer that
// walks the per-tick level memory one tick at a time, reading and checking each
// tick, with an added accumulate step when an impact walk takes volume from it.
// An add, modify or cancel runs the best bid, best ask and two imbalance walks;
// a query runs the two imbalance walks, then the impact or depth walks; each
// division goes through the shared bit-serial divider.
// After reset the level memories and order table are swept clear, one entry a
// cycle, with in_tready low. When the receiver stalls, the output register holds
// the result and the sequencer waits at the next result; the queue keeps
// accepting items until it is full.
module limit_order_book_engine_core (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // order_handle, is_buy, price, quantity, level_count (from bit 0 up)
  input  logic [lob_pkg::IN_DATA_W-1:0]  in_tdata,
  // action
  input  logic [2:0]                     in_tuser,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // status, best_bid, best_ask, bid_present, ask_present, mid_doubled,
  // spread_ticks, imbalance_q15, impact_fine, level_price, level_volume
  output logic [lob_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic                           out_tlast,
  input  logic                           cfg_wr_en,
  input  logic [lob_pkg::CNT_W-1:0]      cfg_wr_data
);
  import lob_pkg::*;

  // The imbalance depth register is clamped once here so that the sequencer
  // always sees a depth between one and the deepest supported level count.
  logic [CNT_W-1:0] imb_depth_r;
  logic [CNT_W-1:0] imb_n;
  logic             q_valid, q_ready, clearing;
  cmd_t             q_cmd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      imb_depth_r <= CNT_W'(IMB_DEPTH_RESET);
    end else if (cfg_wr_en) begin
      imb_depth_r <= cfg_wr_data;
    end
  end

  assign imb_n = clamp_depth(imb_depth_r);

  // Front end: decodes the action and buffers items for the sequencer.
  lob_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .hold      (clearing),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .q_ready   (q_ready)
  );

  // Back end: order table, level memory, walks, divider and result register.
  lob_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_cmd      (q_cmd),
    .q_ready    (q_ready),
    .imb_n      (imb_n),
    .clearing   (clearing),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

FILE: rtl/lob_front.sv
module lob_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          hold,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // order_handle, is_buy, price, quantity, level_count (from bit 0 up)
  input  logic [lob_pkg::IN_DATA_W-1:0] in_tdata,
  // action
  input  logic [2:0]                    in_tuser,
  output logic                          q_valid,
  output lob_pkg::cmd_t                 q_cmd,
  input  logic                          q_ready
);
  import lob_pkg::*;

  cmd_t       fifo_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r;
  logic       push, pop;
  in_word_t   iw;
  cmd_t       cmd_in;

  assign iw = in_word_t'(in_tdata);

  always_comb begin
    cmd_in.handle = iw.order_handle;
    cmd_in.buy    = iw.is_buy;
    cmd_in.price  = iw.price;
    cmd_in.qty    = iw.quantity;
    cmd_in.cnt    = clamp_depth(iw.level_count);
    unique case (in_tuser)
      ACT_ADD:       cmd_in.act = ACT_ADD;
      ACT_MODIFY:    cmd_in.act = ACT_MODIFY;
      ACT_CANCEL:    cmd_in.act = ACT_CANCEL;
      ACT_IMPACT:    cmd_in.act = ACT_IMPACT;
      ACT_DEPTH_BID: cmd_in.act = ACT_DEPTH_BID;
      ACT_DEPTH_ASK: cmd_in.act = ACT_DEPTH_ASK;
      default:       cmd_in.act = ACT_NOP;
    endcase
  end

  assign in_tready = !hold && (count_r != 2'd2);
  assign push      = in_tvalid && in_tready;
  assign q_valid   = (count_r != 2'd0);
  assign pop       = q_valid && q_ready;
  assign q_cmd     = fifo_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wr_ptr_r] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (pop)  rd_ptr_r <= !rd_ptr_r;
      count_r <= count_r + 2'(push) - 2'(pop);
    end
  end

endmodule

FILE: rtl/lob_div.sv
module lob_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [lob_pkg::DIV_NUM_W-1:0] num,
  input  logic [lob_pkg::DIV_DEN_W-1:0] den,
  output logic                          done,
  output logic [lob_pkg::DIV_NUM_W-1:0] quot
);
  import lob_pkg::*;

  logic [DIV_DEN_W-1:0] rem_r, den_r;
  logic [DIV_NUM_W-1:0] quot_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic                 busy_r, done_r;
  logic [DIV_DEN_W:0]   trial;
  logic                 qbit;

  // Restoring division, one quotient bit per cycle.
  assign trial = {rem_r, quot_r[DIV_NUM_W-1]};
  assign qbit  = (trial >= {1'b0, den_r});

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r  <= '0;
      den_r  <= den;
      quot_r <= num;
    end else if (busy_r) begin
      rem_r  <= qbit ? DIV_DEN_W'(trial - {1'b0, den_r}) : trial[DIV_DEN_W-1:0];
      quot_r <= {quot_r[DIV_NUM_W-2:0], qbit};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= DIV_CNT_W'(DIV_NUM_W - 1);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quot = quot_r;

endmodule

FILE: rtl/lob_back.sv
module lob_back (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           q_valid,
  input  lob_pkg::cmd_t                  q_cmd,
  output logic                           q_ready,
  input  logic [lob_pkg::CNT_W-1:0]      imb_n,
  output logic                           clearing,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [lob_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic                           out_tlast
);
  import lob_pkg::*;

  state_t state_r, state_nxt;
  phase_t phase_r, start_phase, fin_phase;
  state_t fin_state;
  logic   start_walk, fin_walk;

  cmd_t                  cmd_r;
  logic [1:0]            status_r;
  logic [LVL_ADDR_W-1:0] clr_r;

  slot_t                 slot_mem [ORDER_SLOTS];
  slot_t                 slot_rd_r, slot_wdata;
  logic                  slot_we;
  logic [HANDLE_W-1:0]   slot_waddr, slot_raddr;

  logic [VOL_W-1:0]      lvl_mem [2*PRICE_TICKS];
  logic [VOL_W-1:0]      lvl_rd_r, lvl_wdata;
  logic                  lvl_we;
  logic [LVL_ADDR_W-1:0] lvl_waddr, lvl_raddr, lvl_addr_r, mut_addr;

  logic [QTY_W-1:0]      add_q_r, sub_q_r;
  logic                  slot_ok;
  logic [1:0]            slot_status;

  logic [PRICE_W-1:0]    i_r, wp;
  logic                  walk_bid, last_idx, nz, ck_done;
  logic [CNT_W-1:0]      found_r, k_r, k_now, n_phase;
  logic [SUM_W-1:0]      sum_b_r, sum_a_r;
  logic [QTY_W-1:0]      rem_r, e_r, take;
  logic [PROD_W-1:0]     w_r, prod_r;

  logic [PRICE_W-1:0]    top_bid_r, top_ask_r;
  logic                  have_bid_r, have_ask_r;
  logic [15:0]           imb_r;
  logic [23:0]           impact_r;
  logic [PRICE_W-1:0]    lvl_price_r;
  logic [VOL_W-1:0]      lvl_vol_r;
  logic                  lvl_last;

  logic                  out_valid_r, out_last_r;
  out_word_t             out_data_r, res;
  logic                  out_free, emit_one, emit_lvl;

  logic                  div_start, div_done;
  logic [DIV_NUM_W-1:0]  div_num, div_quot;
  logic [DIV_DEN_W-1:0]  div_den;
  logic [SUM_W-1:0]      diff;
  logic [SUM_W:0]        tot;
  logic [16:0]           imb_q;
  logic [21:0]           avg;
  logic [19:0]           mid_fine;
  logic                  two;

  lob_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_quot)
  );

  // Memories
  always_ff @(posedge clk) begin
    if (slot_we) slot_mem[slot_waddr] <= slot_wdata;
    slot_rd_r <= slot_mem[slot_raddr];
  end

  always_ff @(posedge clk) begin
    if (lvl_we) lvl_mem[lvl_waddr] <= lvl_wdata;
    lvl_rd_r <= lvl_mem[lvl_raddr];
  end

  // Walk addressing
  always_comb begin
    unique case (phase_r)
      PH_BEST_BID, PH_IMB_BID: walk_bid = 1'b1;
      PH_BEST_ASK, PH_IMB_ASK: walk_bid = 1'b0;
      PH_IMPACT:               walk_bid = !cmd_r.buy;
      default:                 walk_bid = (cmd_r.act == ACT_DEPTH_BID);
    endcase
  end

  assign wp       = walk_bid ? ~i_r : i_r;
  assign last_idx = (i_r == '1);
  assign nz       = (lvl_rd_r != '0);
  assign k_now    = found_r + CNT_W'(nz);
  assign n_phase  = (phase_r == PH_COUNT) ? cmd_r.cnt : imb_n;
  assign take     = (lvl_rd_r < {{(VOL_W-QTY_W){1'b0}}, rem_r}) ? lvl_rd_r[QTY_W-1:0] : rem_r;
  assign lvl_last = (CNT_W'(found_r + 1'b1) == k_r);

  always_comb begin
    unique case (phase_r)
      PH_BEST_BID, PH_BEST_ASK: ck_done = nz || last_idx;
      PH_IMB_BID, PH_IMB_ASK, PH_COUNT:
        ck_done = (nz && (CNT_W'(found_r + 1'b1) == n_phase)) || last_idx;
      default: ck_done = !nz && last_idx;
    endcase
  end

  // Mutation decision on the slot read
  always_comb begin
    slot_ok     = 1'b0;
    slot_status = STAT_OK;
    slot_wdata  = slot_rd_r;
    mut_addr    = {slot_rd_r.side, slot_rd_r.price};
    unique case (cmd_r.act)
      ACT_ADD: begin
        mut_addr = {cmd_r.buy, cmd_r.price};
        slot_wdata = '{valid: 1'b1, side: cmd_r.buy, price: cmd_r.price, qty: cmd_r.qty};
        if (slot_rd_r.valid || cmd_r.qty == '0) slot_status = STAT_REJECT;
        else slot_ok = 1'b1;
      end
      ACT_MODIFY: begin
        slot_wdata.qty = cmd_r.qty;
        if (!slot_rd_r.valid) slot_status = STAT_UNKNOWN;
        else if (cmd_r.qty == '0) slot_status = STAT_REJECT;
        else slot_ok = 1'b1;
      end
      default: begin
        slot_wdata.valid = 1'b0;
        if (!slot_rd_r.valid) slot_status = STAT_UNKNOWN;
        else slot_ok = 1'b1;
      end
    endcase
    // The sweep after reset writes empty slots.
    if (state_r == S_CLEAR) slot_wdata = '0;
  end

  // What follows a finished walk
  always_comb begin
    fin_walk  = 1'b0;
    fin_phase = phase_r;
    fin_state = S_IDLE;
    unique case (phase_r)
      PH_BEST_BID: begin fin_walk = 1'b1; fin_phase = PH_BEST_ASK; fin_state = S_WALK_RD; end
      PH_BEST_ASK: begin fin_walk = 1'b1; fin_phase = PH_IMB_BID; fin_state = S_WALK_RD; end
      PH_IMB_BID:  begin fin_walk = 1'b1; fin_phase = PH_IMB_ASK; fin_state = S_WALK_RD; end
      PH_IMB_ASK:  fin_state = S_DIV_START;
      PH_IMPACT:   fin_state = (e_r == '0) ? S_EMIT_ONE : S_DIV_START;
      PH_COUNT: begin
        if (k_now == '0) begin
          fin_state = S_EMIT_ONE;
        end else begin
          fin_walk = 1'b1; fin_phase = PH_LEVELS; fin_state = S_WALK_RD;
        end
      end
      default:     fin_state = S_IDLE;
    endcase
  end

  assign out_free = !out_valid_r || out_tready;

  // Next state
  always_comb begin
    state_nxt   = state_r;
    start_walk  = 1'b0;
    start_phase = phase_r;
    unique case (state_r)
      S_CLEAR: if (clr_r == '1) state_nxt = S_IDLE;
      S_IDLE: begin
        if (q_valid) begin
          if (q_cmd.act == ACT_ADD || q_cmd.act == ACT_MODIFY || q_cmd.act == ACT_CANCEL) begin
            state_nxt = S_SLOT_CK;
          end else begin
            state_nxt = S_WALK_RD; start_walk = 1'b1; start_phase = PH_IMB_BID;
          end
        end
      end
      S_SLOT_CK: begin
        if (slot_ok) begin
          state_nxt = S_LVL_WR;
        end else begin
          state_nxt = S_WALK_RD; start_walk = 1'b1; start_phase = PH_BEST_BID;
        end
      end
      S_LVL_WR: begin
        state_nxt = S_WALK_RD; start_walk = 1'b1; start_phase = PH_BEST_BID;
      end
      S_WALK_RD: state_nxt = S_WALK_CK;
      S_WALK_CK: begin
        priority if (phase_r == PH_LEVELS && nz) begin
          state_nxt = S_EMIT_LVL;
        end else if (phase_r == PH_IMPACT && nz) begin
          state_nxt = S_WALK_ACC;
        end else if (ck_done) begin
          state_nxt = fin_state; start_walk = fin_walk; start_phase = fin_phase;
        end else begin
          state_nxt = S_WALK_RD;
        end
      end
      S_WALK_ACC: begin
        if (rem_r == '0 || last_idx) begin
          state_nxt = fin_state; start_walk = fin_walk; start_phase = fin_phase;
        end else begin
          state_nxt = S_WALK_RD;
        end
      end
      S_DIV_START: state_nxt = S_DIV_WAIT;
      S_DIV_WAIT: begin
        if (div_done) begin
          if (phase_r == PH_IMB_ASK && cmd_r.act == ACT_IMPACT) begin
            state_nxt = S_WALK_RD; start_walk = 1'b1; start_phase = PH_IMPACT;
          end else if (phase_r == PH_IMB_ASK &&
                       (cmd_r.act == ACT_DEPTH_BID || cmd_r.act == ACT_DEPTH_ASK)) begin
            state_nxt = S_WALK_RD; start_walk = 1'b1; start_phase = PH_COUNT;
          end else begin
            state_nxt = S_EMIT_ONE;
          end
        end
      end
      S_EMIT_LVL: begin
        if (out_free) state_nxt = (lvl_last || last_idx) ? S_IDLE : S_WALK_RD;
      end
      S_EMIT_ONE: if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Outputs: memory control, queue pop, divider start, result emission
  always_comb begin
    slot_we    = 1'b0;
    slot_waddr = cmd_r.handle;
    slot_raddr = q_cmd.handle;
    lvl_we     = 1'b0;
    lvl_waddr  = lvl_addr_r;
    lvl_wdata  = VOL_W'(lvl_rd_r - {{(VOL_W-QTY_W){1'b0}}, sub_q_r}
                        + {{(VOL_W-QTY_W){1'b0}}, add_q_r});
    lvl_raddr  = {walk_bid, wp};
    unique case (state_r)
      S_CLEAR: begin
        slot_we    = (clr_r < LVL_ADDR_W'(ORDER_SLOTS));
        slot_waddr = clr_r[HANDLE_W-1:0];
        lvl_we     = 1'b1;
        lvl_waddr  = clr_r;
        lvl_wdata  = '0;
      end
      S_SLOT_CK: begin
        slot_we   = slot_ok;
        lvl_raddr = mut_addr;
      end
      S_LVL_WR: lvl_we = 1'b1;
      default: ;
    endcase
  end

  assign q_ready   = (state_r == S_IDLE);
  assign clearing  = (state_r == S_CLEAR);
  assign div_start = (state_r == S_DIV_START);
  assign emit_one  = (state_r == S_EMIT_ONE) && out_free;
  assign emit_lvl  = (state_r == S_EMIT_LVL) && out_free;

  // Divider operands
  assign diff = (sum_b_r >= sum_a_r) ? (sum_b_r - sum_a_r) : (sum_a_r - sum_b_r);
  assign tot  = {1'b0, sum_b_r} + {1'b0, sum_a_r};
  always_comb begin
    if (phase_r == PH_IMB_ASK) begin
      div_num = DIV_NUM_W'({diff, 15'b0});
      div_den = DIV_DEN_W'(tot);
    end else begin
      div_num = DIV_NUM_W'({w_r, 9'b0}) + DIV_NUM_W'(e_r);
      div_den = DIV_DEN_W'({e_r, 1'b0});
    end
  end

  assign imb_q    = div_quot[16:0];
  assign avg      = div_quot[21:0];
  assign two      = have_bid_r && have_ask_r;
  assign mid_fine = two ? {(13'(top_bid_r) + 13'(top_ask_r)), 7'b0} : '0;

  // Result word from the current top of book, imbalance, impact and depth level
  always_comb begin
    res               = '0;
    res.status        = status_r;
    res.best_bid      = top_bid_r;
    res.best_ask      = top_ask_r;
    res.bid_present   = have_bid_r;
    res.ask_present   = have_ask_r;
    res.mid_doubled   = two ? 13'(top_bid_r) + 13'(top_ask_r) : '0;
    res.spread_ticks  = two ? ((top_ask_r >= top_bid_r) ? top_ask_r - top_bid_r : '0)
                            : 12'(PRICE_TICKS - 1);
    res.imbalance_q15 = imb_r;
    res.impact_fine   = impact_r;
    if (state_r == S_EMIT_LVL) begin
      res.level_price  = lvl_price_r;
      res.level_volume = lvl_vol_r;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        cmd_r    <= q_cmd;
        status_r <= STAT_OK;
        impact_r <= '0;
      end
      S_SLOT_CK: begin
        status_r   <= slot_status;
        lvl_addr_r <= mut_addr;
        add_q_r    <= (cmd_r.act == ACT_CANCEL) ? '0 : cmd_r.qty;
        sub_q_r    <= (cmd_r.act == ACT_ADD) ? '0 : slot_rd_r.qty;
      end
      S_WALK_CK: begin
        unique case (phase_r)
          PH_IMB_BID: if (nz) begin
            sum_b_r <= sum_b_r + SUM_W'(lvl_rd_r);
            if (!start_walk) found_r <= k_now;
          end
          PH_IMB_ASK: if (nz) begin
            sum_a_r <= sum_a_r + SUM_W'(lvl_rd_r);
            if (!start_walk) found_r <= k_now;
          end
          PH_COUNT: begin
            k_r <= k_now;
            if (!start_walk) found_r <= k_now;
          end
          PH_LEVELS: if (nz) begin
            lvl_price_r <= wp; lvl_vol_r <= lvl_rd_r;
          end
          PH_IMPACT: if (nz) begin
            rem_r  <= rem_r - take;
            e_r    <= e_r + take;
            prod_r <= {{PRICE_W{1'b0}}, take} * {{QTY_W{1'b0}}, wp};
          end
          default: ;
        endcase
      end
      S_WALK_ACC: w_r <= w_r + prod_r;
      S_DIV_WAIT: begin
        if (div_done) begin
          if (phase_r == PH_IMB_ASK) begin
            if (tot == '0) imb_r <= '0;
            else if (sum_b_r >= sum_a_r) imb_r <= imb_q[15] ? 16'h7FFF : imb_q[15:0];
            else imb_r <= 16'(17'd0 - imb_q);
          end else begin
            impact_r <= cmd_r.buy ? 24'({2'b0, avg} - {4'b0, mid_fine})
                                  : 24'({4'b0, mid_fine} - {2'b0, avg});
          end
        end
      end
      S_EMIT_LVL: if (emit_lvl) found_r <= found_r + 1'b1;
      default: ;
    endcase

    if (state_r != S_WALK_RD && state_nxt == S_WALK_RD && !start_walk) begin
      i_r <= i_r + 1'b1;
    end

    if (start_walk) begin
      i_r     <= '0;
      found_r <= '0;
      unique case (start_phase)
        PH_IMB_BID: sum_b_r <= '0;
        PH_IMB_ASK: sum_a_r <= '0;
        PH_IMPACT: begin
          rem_r <= cmd_r.qty; e_r <= '0; w_r <= '0;
        end
        default: ;
      endcase
    end

    if (emit_one || emit_lvl) begin
      out_data_r <= res;
      out_last_r <= emit_one || lvl_last;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      phase_r     <= PH_BEST_BID;
      clr_r       <= '0;
      top_bid_r   <= '0;
      top_ask_r   <= PRICE_W'(PRICE_TICKS - 1);
      have_bid_r  <= 1'b0;
      have_ask_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLEAR) clr_r <= clr_r + 1'b1;
      if (start_walk) phase_r <= start_phase;
      if (start_walk && start_phase == PH_BEST_BID) begin
        have_bid_r <= 1'b0;
        top_bid_r  <= '0;
      end
      if (start_walk && start_phase == PH_BEST_ASK) begin
        have_ask_r <= 1'b0;
        top_ask_r  <= PRICE_W'(PRICE_TICKS - 1);
      end
      if (state_r == S_WALK_CK && nz && phase_r == PH_BEST_BID) begin
        have_bid_r <= 1'b1;
        top_bid_r  <= wp;
      end
      if (state_r == S_WALK_CK && nz && phase_r == PH_BEST_ASK) begin
        have_ask_r <= 1'b1;
        top_ask_r  <= wp;
      end
      if (emit_one || emit_lvl) out_valid_r <= 1'b1;
      else if (out_tready)      out_valid_r <= 1'b0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule
